// ===== rtl/core/jsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// jsrm_pkg
// Shared widths, register codes, limit record and sequencer types for the
// joystick servo rate mapper.
// ----------------------------------------------------------------------------
package jsrm_pkg;

    // fixed point layout of the held pulse
    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int AXIS_IDX_W = $clog2(AXES);
    localparam int AXIS_W    = 16;
    localparam int PULSE_W   = 16;
    localparam int US_W      = 16;
    localparam int DT_W      = 16;
    localparam int DT_FRAC   = 16;
    localparam int DB_W      = 15;
    localparam int CMD_W     = PULSE_W + FRAC_BITS;

    // divider: quotient holds 0 .. 1.0 in FRAC_BITS fraction bits
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // shared multiplier
    localparam int MUL_A_W   = QUOT_W + US_W;
    localparam int MUL_W     = MUL_A_W + DT_W;
    localparam int SUM_W     = MUL_W + 2;

    // full deflection in Q.15
    localparam logic [AXIS_W-1:0] FULL_SCALE = 16'h8000;

    // configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRIPPER  = 2'd3;

    localparam logic [DB_W-1:0]  DEADBAND_RESET = 15'd1638;
    localparam logic [CFG_W-1:0] LIMITS_RESET   = 64'h000107D005DC0158;

    // packed limits of one axis, same bit layout as the register
    typedef struct packed {
        logic [US_W-1:0] rate;
        logic [US_W-1:0] max_us;
        logic [US_W-1:0] center_us;
        logic [US_W-1:0] min_us;
    } limits_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_SPAN,
        ST_MUL_RATE,
        ST_MUL_DT,
        ST_UPDATE,
        ST_DONE
    } seq_state_t;

    // sequencer controls to the datapath
    typedef struct packed {
        logic capture;
        logic clear_all;
        logic div_start;
        logic mul_en;
        logic update;
        logic advance;
        logic load_out;
    } seq_ctl_t;

    // limits are usable when min > 0, min <= center <= max and rate > 0
    function automatic logic limits_ok(limits_t l);
        return (l.min_us != '0) && (l.min_us <= l.center_us) &&
               (l.center_us <= l.max_us) && (l.rate != '0);
    endfunction

endpackage

// ===== rtl/core/jsrm_in_if.sv =====
// ----------------------------------------------------------------------------
// jsrm_in_if
// Stick channel: online flag, three axis deflections and the time step.
// ----------------------------------------------------------------------------
interface jsrm_in_if import jsrm_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     online;
    logic signed [AXIS_W-1:0] pitch_defl;
    logic signed [AXIS_W-1:0] yaw_defl;
    logic signed [AXIS_W-1:0] gripper_defl;
    logic        [DT_W-1:0]   time_step;

    modport source (
        output valid, online, pitch_defl, yaw_defl, gripper_defl, time_step,
        input  ready
    );

    modport sink (
        input  valid, online, pitch_defl, yaw_defl, gripper_defl, time_step,
        output ready
    );

endinterface

// ===== rtl/core/jsrm_out_if.sv =====
// ----------------------------------------------------------------------------
// jsrm_out_if
// Servo channel: one pulse width per axis in microseconds.
// ----------------------------------------------------------------------------
interface jsrm_out_if import jsrm_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pitch_pulse;
    logic [PULSE_W-1:0] yaw_pulse;
    logic [PULSE_W-1:0] gripper_pulse;

    modport source (
        output valid, pitch_pulse, yaw_pulse, gripper_pulse,
        input  ready
    );

    modport sink (
        input  valid, pitch_pulse, yaw_pulse, gripper_pulse,
        output ready
    );

endinterface

// ===== rtl/core/jsrm_div.sv =====
// ----------------------------------------------------------------------------
// jsrm_div
// Restoring divider for the deadband rescale: floor((num << FRAC_BITS) / den)
// with num <= den, one quotient bit per cycle after a first compare.
// ----------------------------------------------------------------------------
module jsrm_div import jsrm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AXIS_W-1:0] num,
    input  logic [AXIS_W-1:0] den,
    output logic [QUOT_W-1:0] quot,
    output logic              done
);

    logic [AXIS_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [AXIS_W:0]   shifted;
    logic [AXIS_W:0]   diff;
    logic              ge;
    logic              first_ge;

    // one compare and subtract step
    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        diff     = shifted - {1'b0, den};
        ge       = shifted >= {1'b0, den};
        first_ge = num >= den;
    end

    // step sequencing
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = first_ge ? (num - den) : num;
            quot_next = {{(QUOT_W-1){1'b0}}, first_ge};
            cnt_next  = CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[AXIS_W-1:0] : shifted[AXIS_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/joystick_servo_rate_mapper.sv =====
// ----------------------------------------------------------------------------
// joystick_servo_rate_mapper
// Maps three stick axes to rate limited servo pulse widths, one tick at a time.
// ----------------------------------------------------------------------------
// A tick that resets the axes goes straight to the result; otherwise each
// axis is checked against the deadband in turn, and a deflected axis passes
// through the shared divider, one or two multiplier passes and one update.
// A new tick is taken only in idle, after the last result has been loaded;
// the divider and the single multiplier are shared by all three axes in turn.
// Reset: configuration registers take their default values, all axes
// inactive at center, no result pending.
module joystick_servo_rate_mapper import jsrm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    jsrm_in_if.sink              stick,
    jsrm_out_if.source           servo,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    // configuration
    logic [DB_W-1:0] deadband_reg;
    limits_t         lim_reg [AXES];

    // sequencer
    seq_state_t            state_reg, state_next;
    seq_ctl_t              ctl;
    logic [AXIS_IDX_W-1:0] k_reg;
    logic                  neg_reg;

    // captured transaction
    logic [AXIS_W-1:0] axis_reg [AXES];
    logic [DT_W-1:0]   dt_reg;

    // axis state
    logic [CMD_W-1:0] cmd_reg [AXES];
    logic             active_reg [AXES];

    // shared multiplier result
    logic [MUL_W-1:0] mul_reg;

    // result register
    logic               out_valid_reg;
    logic [PULSE_W-1:0] out_pulse_reg [AXES];

    logic accept;
    logic regs_ok;
    logic bad_tick;
    logic last_axis;
    logic out_free;

    logic [AXIS_W-1:0] cur_axis;
    limits_t           cur_lim;
    logic              neg_now;
    logic [AXIS_W-1:0] mag;
    logic              in_deadband;
    logic [AXIS_W-1:0] div_num;
    logic [AXIS_W-1:0] div_den;
    logic [QUOT_W-1:0] div_quot;
    logic              div_done;

    logic [US_W-1:0]    span;
    logic [MUL_A_W-1:0] mul_a;
    logic [US_W-1:0]    mul_b;
    logic [MUL_W-1:0]   mul_p;

    logic [CMD_W-1:0]        base;
    logic [CMD_W-1:0]        first_pulse;
    logic signed [SUM_W-1:0] mag_s;
    logic signed [SUM_W-1:0] prod_s;
    logic signed [SUM_W-1:0] bias_s;
    logic signed [SUM_W-1:0] delta_s;
    logic signed [SUM_W-1:0] cand_s;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic signed [SUM_W-1:0] clamp_s;
    logic [CMD_W-1:0]        new_pulse;
    logic [CMD_W:0]          rounded [AXES];

    assign accept    = stick.valid && stick.ready;
    assign last_axis = (k_reg == AXIS_IDX_W'(AXES - 1));
    assign out_free  = !out_valid_reg || servo.ready;

    // register sanity over all axes
    always_comb
    begin
        regs_ok = 1'b1;
        for (int j = 0; j < AXES; j++)
        begin
            if (!limits_ok(lim_reg[j]))
            begin
                regs_ok = 1'b0;
            end
        end
    end

    assign bad_tick = !stick.online || (stick.time_step == '0) || !regs_ok;

    // current axis magnitude and deadband test
    always_comb
    begin
        cur_axis    = axis_reg[k_reg];
        cur_lim     = lim_reg[k_reg];
        neg_now     = cur_axis[AXIS_W-1];
        mag         = neg_now ? (~cur_axis + AXIS_W'(1)) : cur_axis;
        in_deadband = mag <= {1'b0, deadband_reg};
        div_num     = mag - {1'b0, deadband_reg};
        div_den     = FULL_SCALE - {1'b0, deadband_reg};
    end

    jsrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // shared multiplier operands
    always_comb
    begin
        span  = neg_reg ? (cur_lim.center_us - cur_lim.min_us)
                        : (cur_lim.max_us - cur_lim.center_us);
        mul_a = {{(MUL_A_W-QUOT_W){1'b0}}, div_quot};
        mul_b = span;
        case (state_reg)
            ST_MUL_SPAN:
            begin
                mul_b = span;
            end
            ST_MUL_RATE:
            begin
                mul_b = cur_lim.rate;
            end
            ST_MUL_DT:
            begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = dt_reg;
            end
            default:
            begin
                mul_b = span;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // new pulse: jump from center, or rate step with rounding and clamp
    always_comb
    begin
        base        = {cur_lim.center_us, {FRAC_BITS{1'b0}}};
        first_pulse = neg_reg ? (base - mul_reg[CMD_W-1:0])
                              : (base + mul_reg[CMD_W-1:0]);
        mag_s   = $signed({2'b00, mul_reg});
        prod_s  = neg_reg ? -mag_s : mag_s;
        bias_s  = $signed(SUM_W'(1) << (DT_FRAC - 1));
        delta_s = (prod_s + bias_s) >>> DT_FRAC;
        cand_s  = delta_s + $signed({{(SUM_W-CMD_W){1'b0}}, cmd_reg[k_reg]});
        lo_s    = $signed({{(SUM_W-CMD_W){1'b0}}, cur_lim.min_us,
                           {FRAC_BITS{1'b0}}});
        hi_s    = $signed({{(SUM_W-CMD_W){1'b0}}, cur_lim.max_us,
                           {FRAC_BITS{1'b0}}});
        if (cand_s < lo_s)
        begin
            clamp_s = lo_s;
        end
        else if (cand_s > hi_s)
        begin
            clamp_s = hi_s;
        end
        else
        begin
            clamp_s = cand_s;
        end
        new_pulse = active_reg[k_reg] ? clamp_s[CMD_W-1:0] : first_pulse;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bad_tick ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_deadband)
                begin
                    state_next = last_axis ? ST_DONE : ST_CHECK;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = active_reg[k_reg] ? ST_MUL_RATE : ST_MUL_SPAN;
                end
            end
            ST_MUL_SPAN:
            begin
                state_next = ST_UPDATE;
            end
            ST_MUL_RATE:
            begin
                state_next = ST_MUL_DT;
            end
            ST_MUL_DT:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = last_axis ? ST_DONE : ST_CHECK;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.capture   = accept;
                ctl.clear_all = accept && bad_tick;
            end
            ST_CHECK:
            begin
                ctl.advance   = in_deadband;
                ctl.div_start = !in_deadband;
            end
            ST_MUL_SPAN, ST_MUL_RATE, ST_MUL_DT:
            begin
                ctl.mul_en = 1'b1;
            end
            ST_UPDATE:
            begin
                ctl.update  = 1'b1;
                ctl.advance = 1'b1;
            end
            ST_DONE:
            begin
                ctl.load_out = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign stick.ready = (state_reg == ST_IDLE);

    // control state, configuration and axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            deadband_reg  <= DEADBAND_RESET;
            for (int j = 0; j < AXES; j++)
            begin
                lim_reg[j]    <= limits_t'(LIMITS_RESET);
                cmd_reg[j]    <= {LIMITS_RESET[2*US_W-1:US_W], {FRAC_BITS{1'b0}}};
                active_reg[j] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (wr_en)
            begin
                case (wr_index)
                    REG_DEADBAND: deadband_reg <= wr_data[DB_W-1:0];
                    REG_PITCH:    lim_reg[0]   <= limits_t'(wr_data);
                    REG_YAW:      lim_reg[1]   <= limits_t'(wr_data);
                    REG_GRIPPER:  lim_reg[2]   <= limits_t'(wr_data);
                    default:      deadband_reg <= deadband_reg;
                endcase
            end

            // axis walk
            if (ctl.capture)
            begin
                k_reg <= '0;
            end
            else if (ctl.advance && !last_axis)
            begin
                k_reg <= k_reg + AXIS_IDX_W'(1);
            end

            // link drop, zero step or bad limits
            if (ctl.clear_all)
            begin
                for (int j = 0; j < AXES; j++)
                begin
                    cmd_reg[j]    <= {lim_reg[j].center_us, {FRAC_BITS{1'b0}}};
                    active_reg[j] <= 1'b0;
                end
            end

            if (ctl.update)
            begin
                cmd_reg[k_reg]    <= new_pulse;
                active_reg[k_reg] <= 1'b1;
            end

            // result handshake
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (servo.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output rounding, half up
    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            rounded[j] = {1'b0, cmd_reg[j]} + (CMD_W+1)'(1 << (FRAC_BITS - 1));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            axis_reg[0] <= stick.pitch_defl;
            axis_reg[1] <= stick.yaw_defl;
            axis_reg[2] <= stick.gripper_defl;
            dt_reg      <= stick.time_step;
        end
        if (ctl.div_start)
        begin
            neg_reg <= neg_now;
        end
        if (ctl.mul_en)
        begin
            mul_reg <= mul_p;
        end
        if (ctl.load_out)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                if (active_reg[j] && (cmd_reg[j] != '0))
                begin
                    out_pulse_reg[j] <= rounded[j][PULSE_W+FRAC_BITS-1:FRAC_BITS];
                end
                else
                begin
                    out_pulse_reg[j] <= '0;
                end
            end
        end
    end

    assign servo.valid         = out_valid_reg;
    assign servo.pitch_pulse   = out_pulse_reg[0];
    assign servo.yaw_pulse     = out_pulse_reg[1];
    assign servo.gripper_pulse = out_pulse_reg[2];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joystick servo rate mapper: drives stick ticks
// and register settings, predicts each servo pulse triple in fixed point and
// compares every result transaction field by field, under random idling and
// long output stalls.
// ----------------------------------------------------------------------------
module tb;
    import jsrm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_TICKS  = 1300;
    localparam int TAIL_CYCLES   = 80;
    localparam int LONG_HOLD     = 400;
    localparam longint FULL_DEFL = 32768;

    // one stick tick as offered on the input channel
    typedef struct packed {
        logic                     online;
        logic signed [AXIS_W-1:0] pitch;
        logic signed [AXIS_W-1:0] yaw;
        logic signed [AXIS_W-1:0] gripper;
        logic        [DT_W-1:0]   time_step;
    } tick_t;

    // one pulse triple as returned on the output channel
    typedef struct packed {
        logic [PULSE_W-1:0] pitch;
        logic [PULSE_W-1:0] yaw;
        logic [PULSE_W-1:0] gripper;
    } servo_t;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    jsrm_in_if  stick_if ();
    jsrm_out_if servo_if ();

    joystick_servo_rate_mapper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .stick    (stick_if),
        .servo    (servo_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // predicted block state and register copy
    logic [DB_W-1:0] db_cfg;
    limits_t         lim_cfg [AXES];
    longint          held_pulse [AXES];
    bit              axis_on [AXES];

    servo_t expected_pulses [$];

    int  fail_count    = 0;
    int  ticks_sent    = 0;
    int  pulses_seen   = 0;
    int  settings_used = 0;
    bit  tx_no_idle    = 0;
    bit  rx_no_idle    = 0;
    int  rx_hold       = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $error("run limit of %0d cycles reached, %0d results outstanding",
               CYCLE_LIMIT, expected_pulses.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic bit limits_usable();
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < AXES; k++)
        begin
            if (lim_cfg[k].min_us == 0 || lim_cfg[k].min_us > lim_cfg[k].center_us ||
                lim_cfg[k].center_us > lim_cfg[k].max_us || lim_cfg[k].rate == 0)
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic void park_axes();
        for (int k = 0; k < AXES; k++)
        begin
            held_pulse[k] = longint'(lim_cfg[k].center_us) <<< FRAC_BITS;
            axis_on[k]    = 1'b0;
        end
    endfunction

    function automatic void reset_model();
        db_cfg = DEADBAND_RESET;
        for (int k = 0; k < AXES; k++)
            lim_cfg[k] = LIMITS_RESET;
        park_axes();
    endfunction

    // advance the axis state by one tick and return the pulses it shows
    function automatic servo_t predict_pulses(input tick_t t);
        longint defl [AXES];
        longint shown [AXES];
        longint db, dt, mag, scaled, span, pulse, lo, hi, lmin, lctr, lmax, lrate;
        servo_t r;
        defl[0] = longint'($signed(t.pitch));
        defl[1] = longint'($signed(t.yaw));
        defl[2] = longint'($signed(t.gripper));
        db = longint'(db_cfg);
        dt = longint'(t.time_step);
        if (!t.online || dt == 0 || !limits_usable())
            park_axes();
        else
        begin
            for (int k = 0; k < AXES; k++)
            begin
                mag = (defl[k] < 0) ? -defl[k] : defl[k];
                if (mag > db)
                begin
                    lmin   = longint'(lim_cfg[k].min_us);
                    lctr   = longint'(lim_cfg[k].center_us);
                    lmax   = longint'(lim_cfg[k].max_us);
                    lrate  = longint'(lim_cfg[k].rate);
                    scaled = ((mag - db) <<< FRAC_BITS) / (FULL_DEFL - db);
                    if (defl[k] < 0)
                        scaled = -scaled;
                    if (!axis_on[k])
                    begin
                        // first deflection jumps within the half-span
                        span  = (defl[k] < 0) ? (lctr - lmin) : (lmax - lctr);
                        pulse = (lctr <<< FRAC_BITS) + scaled * span;
                    end
                    else
                    begin
                        // rate move, rounded half up, then clamped
                        lo    = lmin <<< FRAC_BITS;
                        hi    = lmax <<< FRAC_BITS;
                        pulse = held_pulse[k] +
                                ((scaled * lrate * dt + (64'sd1 <<< (DT_FRAC - 1))) >>>
                                 DT_FRAC);
                        if (pulse < lo)
                            pulse = lo;
                        if (pulse > hi)
                            pulse = hi;
                    end
                    held_pulse[k] = pulse;
                    axis_on[k]    = 1'b1;
                end
            end
        end
        for (int k = 0; k < AXES; k++)
        begin
            shown[k] = 0;
            if (axis_on[k] && held_pulse[k] > 0)
                shown[k] = (held_pulse[k] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
        r.pitch   = shown[0][PULSE_W-1:0];
        r.yaw     = shown[1][PULSE_W-1:0];
        r.gripper = shown[2][PULSE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // servo side: ready generation and result checking
    // ------------------------------------------------------------------------

    // per-result stalls plus long holds requested by a test
    initial
    begin : servo_ready_gen
        int stall;
        stall = 0;
        servo_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (servo_if.valid && servo_if.ready)
                stall = rx_no_idle ? 0 : $urandom_range(0, 8);
            if (rx_hold > 0)
            begin
                rx_hold = rx_hold - 1;
                servo_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                servo_if.ready <= 1'b0;
            end
            else
                servo_if.ready <= 1'b1;
        end
    end

    // compare each servo transaction with the oldest prediction
    initial
    begin : servo_check
        servo_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && servo_if.valid && servo_if.ready)
            begin
                pulses_seen++;
                if (expected_pulses.size() == 0)
                begin
                    $error("servo transaction with no tick pending: %0d %0d %0d",
                           servo_if.pitch_pulse, servo_if.yaw_pulse,
                           servo_if.gripper_pulse);
                    fail_count++;
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    if (servo_if.pitch_pulse !== want.pitch)
                    begin
                        $error("pitch_pulse expected %0d got %0d", want.pitch,
                               servo_if.pitch_pulse);
                        fail_count++;
                    end
                    if (servo_if.yaw_pulse !== want.yaw)
                    begin
                        $error("yaw_pulse expected %0d got %0d", want.yaw,
                               servo_if.yaw_pulse);
                        fail_count++;
                    end
                    if (servo_if.gripper_pulse !== want.gripper)
                    begin
                        $error("gripper_pulse expected %0d got %0d", want.gripper,
                               servo_if.gripper_pulse);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stick side and register helpers
    // ------------------------------------------------------------------------

    // offer one tick, wait for the handshake and record its prediction
    task automatic send_tick(input logic on, input int p, input int y, input int g,
                             input int dt);
        tick_t t;
        int    gap;
        t.online    = on;
        t.pitch     = p[AXIS_W-1:0];
        t.yaw       = y[AXIS_W-1:0];
        t.gripper   = g[AXIS_W-1:0];
        t.time_step = dt[DT_W-1:0];
        gap = tx_no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            stick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stick_if.valid        <= 1'b1;
        stick_if.online       <= t.online;
        stick_if.pitch_defl   <= t.pitch;
        stick_if.yaw_defl     <= t.yaw;
        stick_if.gripper_defl <= t.gripper;
        stick_if.time_step    <= t.time_step;
        @(posedge clk);
        while (!stick_if.ready)
            @(posedge clk);
        expected_pulses.push_back(predict_pulses(t));
        ticks_sent++;
    endtask

    // drop valid and wait until every predicted result has been checked
    task automatic wait_drain();
        stick_if.valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all four registers while the block is idle
    task automatic set_config(input logic [DB_W-1:0] db, input limits_t lp,
                              input limits_t ly, input limits_t lg);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        idx = '{REG_DEADBAND, REG_PITCH, REG_YAW, REG_GRIPPER};
        val = '{{{(CFG_W - DB_W){1'b0}}, db}, lp, ly, lg};
        wait_drain();
        for (int i = 0; i < 4; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= val[i];
            @(posedge clk);
            case (idx[i])
                REG_DEADBAND: db_cfg     = val[i][DB_W-1:0];
                REG_PITCH:    lim_cfg[0] = val[i];
                REG_YAW:      lim_cfg[1] = val[i];
                REG_GRIPPER:  lim_cfg[2] = val[i];
                default:      ;
            endcase
        end
        wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic limits_t make_limits(input int lo, input int ctr, input int hi,
                                            input int rate);
        limits_t l;
        l.min_us    = lo[US_W-1:0];
        l.center_us = ctr[US_W-1:0];
        l.max_us    = hi[US_W-1:0];
        l.rate      = rate[US_W-1:0];
        return l;
    endfunction

    // random limits, either usable or broken in one of four ways
    function automatic limits_t rand_limits(input bit usable);
        int a, b, c, s, rate;
        case ($urandom_range(0, 3))
            0:
            begin
                a = $urandom_range(500, 1000);
                b = $urandom_range(1300, 1700);
                c = $urandom_range(1900, 2600);
            end
            1:
            begin
                a = 1;
                b = $urandom_range(1, 65535);
                c = 65535;
            end
            2:
            begin
                a = $urandom_range(1, 65535);
                b = $urandom_range(1, 65535);
                c = $urandom_range(1, 65535);
                if (a > b) begin s = a; a = b; b = s; end
                if (b > c) begin s = b; b = c; c = s; end
                if (a > b) begin s = a; a = b; b = s; end
            end
            default:
            begin
                a = $urandom_range(1, 65535);
                b = a;
                c = a;
            end
        endcase
        case ($urandom_range(0, 3))
            0:       rate = 1;
            1:       rate = 65535;
            default: rate = $urandom_range(1, 3000);
        endcase
        if (!usable)
        begin
            case ($urandom_range(0, 3))
                0: a = 0;
                1: rate = 0;
                2:
                begin
                    b = $urandom_range(1, 65534);
                    a = b + 1;
                    c = $urandom_range(b, 65535);
                end
                default:
                begin
                    c = $urandom_range(1, 65534);
                    b = c + 1;
                    a = $urandom_range(1, b);
                end
            endcase
        end
        return make_limits(a, b, c, rate);
    endfunction

    // deflection biased toward the deadband edges and the full-scale ends
    function automatic int rand_axis();
        int db, v;
        db = int'(db_cfg);
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, db))
                                               : -int'($urandom_range(0, db));
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       v = db;
                    1:       v = db + 1;
                    2:       v = -db;
                    3:       v = -db - 1;
                    4:       v = 32767;
                    default: v = -32768;
                endcase
            end
            2:       v = 0;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic send_random_tick();
        logic on;
        int   dt;
        on = ($urandom_range(0, 24) != 0);
        case ($urandom_range(0, 19))
            0:       dt = 0;
            1:       dt = 65535;
            2:       dt = 1;
            3, 4, 5, 6, 7, 8, 9:
                     dt = $urandom_range(1, 1000);
            default: dt = $urandom_range(1, 65535);
        endcase
        send_tick(on, rand_axis(), rand_axis(), rand_axis(), dt);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: jumps, deadband edges, link drop and zero time step
    task automatic test_first_deflection();
        send_tick(1'b1, 32767, -32768, 0, 655);
        send_tick(1'b1, 1638, -1639, 1639, 655);
        send_tick(1'b1, 32767, -32768, 12000, 65535);
        send_tick(1'b0, 32767, 32767, 32767, 655);
        send_tick(1'b1, 5000, -5000, -1638, 0);
    endtask

    // zero deadband, slowest and fastest rates: tiny moves, clamps and a held pulse
    task automatic test_rate_and_clamp();
        limits_t fast;
        fast = make_limits(1000, 1500, 2000, 65535);
        set_config('0, make_limits(1000, 1500, 2000, 1), fast, fast);
        send_tick(1'b1, 1, -1, 0, 1);
        send_tick(1'b1, 1, -1, 32767, 1);
        send_tick(1'b1, 32767, -32768, 32767, 65535);
        send_tick(1'b1, -32768, 32767, -32768, 65535);
        send_tick(1'b1, 0, 0, 0, 100);
        // new center while active: held pulses keep their value
        set_config('0, make_limits(1100, 1200, 2000, 1), fast, fast);
        send_tick(1'b1, 100, -100, 0, 1);
    endtask

    // register extremes: widest deadband, widest spans, collapsed spans
    task automatic test_register_extremes();
        set_config({DB_W{1'b1}}, make_limits(1, 1, 65535, 65535),
                   make_limits(1, 32768, 65535, 65535),
                   make_limits(65535, 65535, 65535, 1));
        send_tick(1'b1, -32768, 32767, -32768, 65535);
        send_tick(1'b1, 32767, -32768, 32767, 65535);
        send_tick(1'b1, -32768, -32768, -32768, 65535);
        set_config('0, make_limits(1, 65535, 65535, 65535),
                   make_limits(1, 1, 1, 1), make_limits(2, 3, 4, 2));
        send_tick(1'b1, -32768, 32767, 32767, 65535);
        send_tick(1'b1, 32767, -32768, -1, 65535);
        send_tick(1'b1, -32768, 32767, -32768, 1);
    endtask

    // each way of making the limits unusable parks every axis
    task automatic test_invalid_limits();
        limits_t good;
        good = LIMITS_RESET;
        set_config(DEADBAND_RESET, make_limits(0, 1500, 2000, 10), good, good);
        send_tick(1'b1, 32767, 32767, 32767, 655);
        set_config(DEADBAND_RESET, good, make_limits(1600, 1500, 2000, 10), good);
        send_tick(1'b1, -32768, -32768, -32768, 655);
        set_config(DEADBAND_RESET, good, good, make_limits(1000, 2100, 2000, 10));
        send_tick(1'b1, 20000, -20000, 20000, 655);
        set_config(DEADBAND_RESET, make_limits(1000, 1500, 2000, 0), good, good);
        send_tick(1'b1, -20000, 20000, -20000, 655);
    endtask

    // hold the servo side for a long stretch while ticks keep coming
    task automatic test_output_stall();
        set_config(DEADBAND_RESET, rand_limits(1), rand_limits(1), rand_limits(1));
        tx_no_idle = 1'b1;
        rx_hold    = LONG_HOLD;
        repeat (30) send_random_tick();
        tx_no_idle = 1'b0;
    endtask

    // the stick side pauses until every result is back, then resumes
    task automatic test_drain_pause();
        repeat (12) send_random_tick();
        wait_drain();
        repeat (12) send_random_tick();
    endtask

    // random register settings, each followed by a burst of ticks
    task automatic test_random_ticks();
        int             sent, burst;
        logic [DB_W-1:0] db;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            case ($urandom_range(0, 4))
                0:       db = '0;
                1:       db = {DB_W{1'b1}};
                2:       db = DB_W'($urandom_range(0, 4000));
                3:       db = DB_W'($urandom_range(0, 32767));
                default: db = DEADBAND_RESET;
            endcase
            set_config(db, rand_limits($urandom_range(0, 19) != 0),
                       rand_limits($urandom_range(0, 19) != 0),
                       rand_limits($urandom_range(0, 19) != 0));
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(20, 50);
            repeat (burst) send_random_tick();
            sent += burst;
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                 <= 1'b0;
        wr_en                 <= 1'b0;
        wr_index              <= REG_DEADBAND;
        wr_data               <= '0;
        stick_if.valid        <= 1'b0;
        stick_if.online       <= 1'b0;
        stick_if.pitch_defl   <= '0;
        stick_if.yaw_defl     <= '0;
        stick_if.gripper_defl <= '0;
        stick_if.time_step    <= '0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_deflection();
        test_rate_and_clamp();
        test_register_extremes();
        test_invalid_limits();
        test_output_stall();
        test_drain_pause();
        test_random_ticks();

        // let the last results and any stray transaction show up
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_pulses.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_pulses.size());
            fail_count += expected_pulses.size();
        end
        $display("covered %0d stick ticks over %0d register settings", ticks_sent,
                 settings_used);
        $display("compared %0d servo transactions, %0d mismatches", pulses_seen,
                 fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
